// File: rtl/dpr_pkg.sv
// Shared types and constants of the Doppler phase rotator.
`default_nettype none
package dpr_pkg;

   localparam int ANGLE_BITS = 32;
   localparam int CORDIC_BITS = 32;
   localparam int ATAN_DEPTH = 32;

   // 1/gain of the CORDIC in Q2.30
   localparam logic signed [CORDIC_BITS-1:0] INV_GAIN_Q30 = 32'sd652032874;

   // atan(2^-i) in units of 2^-32 turn, truncated
   localparam logic signed [CORDIC_BITS-1:0] ATAN_TURNS [0:ATAN_DEPTH-1] = '{
      32'sd536870912, 32'sd316933405, 32'sd167458907, 32'sd85004756,
      32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
      32'sd2670163,   32'sd1335086,   32'sd667544,    32'sd333772,
      32'sd166886,    32'sd83443,     32'sd41721,     32'sd20860,
      32'sd10430,     32'sd5215,      32'sd2607,      32'sd1303,
      32'sd651,       32'sd325,       32'sd162,       32'sd81,
      32'sd40,        32'sd20,        32'sd10,        32'sd5,
      32'sd2,         32'sd1,         32'sd0,         32'sd0
   };

   typedef enum logic [1:0] {
      QUAD_0   = 2'd0,
      QUAD_90  = 2'd1,
      QUAD_180 = 2'd2,
      QUAD_270 = 2'd3
   } dpr_quad_type;

   typedef struct packed {
      logic         valid;
      logic         last;
      dpr_quad_type quad;
   } dpr_ctl_type;

endpackage
`default_nettype wire

// File: rtl/dpr_phase.sv
// Phase accumulator and quadrant fold feeding the CORDIC chain.
`default_nettype none
module dpr_phase
   import dpr_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int PHASE_BITS  = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire logic                         in_valid,
   input  wire logic                         in_last,
   input  wire logic [4*SAMPLE_BITS-1:0]     in_smp,
   input  wire logic [ANGLE_BITS-1:0]        step,
   output dpr_ctl_type                       ctl_o,
   output logic signed [CORDIC_BITS-1:0]     z_o,
   output logic [4*SAMPLE_BITS-1:0]          smp_o
);

   logic [PHASE_BITS-1:0]            acc_ff, acc_in;
   logic [PHASE_BITS+ANGLE_BITS-1:0] step_wide, sum_wide;
   logic [PHASE_BITS-1:0]            step_p, sum;
   logic [ANGLE_BITS-1:0]            angle, angle_rnd;
   dpr_quad_type                     quad;
   dpr_ctl_type                      ctl_ff, ctl_in;
   logic signed [CORDIC_BITS-1:0]    z_ff, z_in;
   logic [4*SAMPLE_BITS-1:0]         smp_ff;

   // align the 32-bit step and the top 32 angle bits to the accumulator width
   assign step_wide = {step, {PHASE_BITS{1'b0}}};
   assign step_p    = step_wide[PHASE_BITS+ANGLE_BITS-1:ANGLE_BITS];
   assign sum       = acc_ff + step_p;
   assign sum_wide  = {sum, {ANGLE_BITS{1'b0}}};
   assign angle     = sum_wide[PHASE_BITS+ANGLE_BITS-1:PHASE_BITS];

   // fold into the nearest quadrant, residual within plus or minus 1/8 turn
   assign angle_rnd = angle + 32'h2000_0000;
   assign quad      = dpr_quad_type'(angle_rnd[31:30]);

   always_comb begin
      acc_in = acc_ff;
      if (in_valid) begin
         acc_in = in_last ? '0 : sum;
      end
      ctl_in.valid = in_valid;
      ctl_in.last  = in_last;
      ctl_in.quad  = quad;
      z_in         = $signed(angle - {angle_rnd[31:30], 30'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         ctl_ff <= '0;
      end else if (en) begin
         acc_ff <= acc_in;
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z_ff   <= z_in;
         smp_ff <= in_smp;
      end
   end

   assign ctl_o = ctl_ff;
   assign z_o   = z_ff;
   assign smp_o = smp_ff;

endmodule
`default_nettype wire

// File: rtl/dpr_cordic_cell.sv
// One rotation step of the pipelined CORDIC, with the samples riding along.
`default_nettype none
module dpr_cordic_cell
   import dpr_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int STAGE       = 0
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           en,
   input  wire dpr_ctl_type                    ctl_i,
   input  wire logic signed [CORDIC_BITS-1:0]  x_i,
   input  wire logic signed [CORDIC_BITS-1:0]  y_i,
   input  wire logic signed [CORDIC_BITS-1:0]  z_i,
   input  wire logic [4*SAMPLE_BITS-1:0]       smp_i,
   output dpr_ctl_type                         ctl_o,
   output logic signed [CORDIC_BITS-1:0]       x_o,
   output logic signed [CORDIC_BITS-1:0]       y_o,
   output logic signed [CORDIC_BITS-1:0]       z_o,
   output logic [4*SAMPLE_BITS-1:0]            smp_o
);

   localparam logic signed [CORDIC_BITS-1:0] ATAN = ATAN_TURNS[STAGE];

   dpr_ctl_type                   ctl_ff;
   logic signed [CORDIC_BITS-1:0] x_ff, y_ff, z_ff, x_in, y_in, z_in, dx, dy;
   logic [4*SAMPLE_BITS-1:0]      smp_ff;

   assign dx = y_i >>> STAGE;
   assign dy = x_i >>> STAGE;

   always_comb begin
      if (!z_i[CORDIC_BITS-1]) begin
         x_in = x_i - dx;
         y_in = y_i + dy;
         z_in = z_i - ATAN;
      end else begin
         x_in = x_i + dx;
         y_in = y_i - dy;
         z_in = z_i + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         smp_ff <= smp_i;
      end
   end

   assign ctl_o = ctl_ff;
   assign x_o   = x_ff;
   assign y_o   = y_ff;
   assign z_o   = z_ff;
   assign smp_o = smp_ff;

endmodule
`default_nettype wire

// File: rtl/dpr_mixer.sv
// Complex multiply of one sample by (cos, sin), then round and saturate.
`default_nettype none
module dpr_mixer
   import dpr_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           en,
   input  wire logic signed [CORDIC_BITS-1:0]  cos_i,
   input  wire logic signed [CORDIC_BITS-1:0]  sin_i,
   input  wire logic signed [SAMPLE_BITS-1:0]  re_i,
   input  wire logic signed [SAMPLE_BITS-1:0]  im_i,
   output logic signed [SAMPLE_BITS-1:0]       re_o,
   output logic signed [SAMPLE_BITS-1:0]       im_o
);

   localparam int PW = SAMPLE_BITS + CORDIC_BITS;
   localparam int SW = PW + 1;
   localparam int RW = SW - 30;
   localparam logic signed [SW-1:0] HALF = SW'(64'sd536870912);

   logic signed [PW-1:0]          rc_ff, rs_ff, ic_ff, is_ff, rc_in, rs_in, ic_in, is_in;
   logic signed [SW-1:0]          sum_re, sum_im;
   logic signed [SAMPLE_BITS-1:0] re_ff, im_ff, re_in, im_in;

   function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
      input logic signed [SW-1:0] p
   );
      logic signed [SW-1:0] rnd;
      logic [RW-1:0]        v;
      logic [SAMPLE_BITS-1:0] res;
      rnd = p + HALF;
      v   = rnd[SW-1:30];
      // the upper bits must all match the sign for the value to fit
      if (v[RW-1:SAMPLE_BITS-1] == '0 || v[RW-1:SAMPLE_BITS-1] == '1) begin
         res = v[SAMPLE_BITS-1:0];
      end else if (v[RW-1]) begin
         res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
      return $signed(res);
   endfunction

   assign rc_in = re_i * cos_i;
   assign rs_in = re_i * sin_i;
   assign ic_in = im_i * cos_i;
   assign is_in = im_i * sin_i;

   assign sum_re = {rc_ff[PW-1], rc_ff} - {is_ff[PW-1], is_ff};
   assign sum_im = {rs_ff[PW-1], rs_ff} + {ic_ff[PW-1], ic_ff};
   assign re_in  = round_sat(sum_re);
   assign im_in  = round_sat(sum_im);

   always_ff @(posedge clock) begin
      if (en) begin
         rc_ff <= rc_in;
         rs_ff <= rs_in;
         ic_ff <= ic_in;
         is_ff <= is_in;
         re_ff <= re_in;
         im_ff <= im_in;
      end
   end

   assign re_o = re_ff;
   assign im_o = im_ff;

endmodule
`default_nettype wire

// File: rtl/doppler_phase_rotator.sv
// Top level of the Doppler phase rotator: phase NCO, CORDIC cell chain, mixers.
//
// Rotates each H/V sample pair by k*phase_step/2^32 turns, k counting from 1
// within a record; the phase restarts after a transfer with tlast set. One
// sample pair enters per clock while the output is not stalled. A result passes
// through the phase accumulator and quadrant fold register, one register per
// CORDIC cell, the multiplier register and the round/saturate output register.
// The whole chain advances together; while a result waits on rsp_tready the
// chain holds and req_tready is low. A csr write takes effect from the next
// accepted sample and leaves the accumulator alone.
`default_nettype none
module doppler_phase_rotator
   import dpr_pkg::*;
#(
   parameter int SAMPLE_BITS   = 16,
   parameter int PHASE_BITS    = 32,
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // h_real, h_imag, v_real, v_imag from bit 0 up, zero padded to bytes
   input  wire logic [((4*SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,
   input  wire logic                                  req_tlast,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // h_real_out, h_imag_out, v_real_out, v_imag_out from bit 0 up, zero padded
   output logic [((4*SAMPLE_BITS+7)/8)*8-1:0]         rsp_tdata,
   output logic                                       rsp_tlast,
   input  wire logic                                  csr_wr_en,
   input  wire logic [ANGLE_BITS-1:0]                 csr_wr_data
);

   localparam int DATA_W = ((4*SAMPLE_BITS+7)/8)*8;
   localparam int SB     = SAMPLE_BITS;
   localparam int N      = CORDIC_STAGES;

   logic                          en;
   logic [ANGLE_BITS-1:0]         step_ff;
   dpr_ctl_type                   ctl_chain [0:N];
   logic signed [CORDIC_BITS-1:0] x_chain [0:N];
   logic signed [CORDIC_BITS-1:0] y_chain [0:N];
   logic signed [CORDIC_BITS-1:0] z_chain [0:N];
   logic [4*SB-1:0]               smp_chain [0:N];
   logic signed [CORDIC_BITS-1:0] cos_v, sin_v;
   logic                          prod_vld_ff, prod_last_ff, rsp_vld_ff, rsp_last_ff;
   logic signed [SB-1:0]          h_re, h_im, v_re, v_im;

   assign en         = !rsp_vld_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 32'h8000_0000;
      end else if (csr_wr_en) begin
         step_ff <= csr_wr_data;
      end
   end

   dpr_phase #(
      .SAMPLE_BITS (SB),
      .PHASE_BITS  (PHASE_BITS)
   ) u_phase (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .in_last  (req_tlast),
      .in_smp   (req_tdata[4*SB-1:0]),
      .step     (step_ff),
      .ctl_o    (ctl_chain[0]),
      .z_o      (z_chain[0]),
      .smp_o    (smp_chain[0])
   );

   assign x_chain[0] = INV_GAIN_Q30;
   assign y_chain[0] = '0;

   for (genvar i = 0; i < N; i++) begin : g_cell
      dpr_cordic_cell #(
         .SAMPLE_BITS (SB),
         .STAGE       (i)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .ctl_i (ctl_chain[i]),
         .x_i   (x_chain[i]),
         .y_i   (y_chain[i]),
         .z_i   (z_chain[i]),
         .smp_i (smp_chain[i]),
         .ctl_o (ctl_chain[i+1]),
         .x_o   (x_chain[i+1]),
         .y_o   (y_chain[i+1]),
         .z_o   (z_chain[i+1]),
         .smp_o (smp_chain[i+1])
      );
   end

   // unfold the quadrant
   always_comb begin
      unique case (ctl_chain[N].quad)
         QUAD_0: begin
            cos_v = x_chain[N];
            sin_v = y_chain[N];
         end
         QUAD_90: begin
            cos_v = -y_chain[N];
            sin_v = x_chain[N];
         end
         QUAD_180: begin
            cos_v = -x_chain[N];
            sin_v = -y_chain[N];
         end
         default: begin
            cos_v = y_chain[N];
            sin_v = -x_chain[N];
         end
      endcase
   end

   dpr_mixer #(
      .SAMPLE_BITS (SB)
   ) u_mix_h (
      .clock (clock),
      .en    (en),
      .cos_i (cos_v),
      .sin_i (sin_v),
      .re_i  ($signed(smp_chain[N][SB-1:0])),
      .im_i  ($signed(smp_chain[N][2*SB-1:SB])),
      .re_o  (h_re),
      .im_o  (h_im)
   );

   dpr_mixer #(
      .SAMPLE_BITS (SB)
   ) u_mix_v (
      .clock (clock),
      .en    (en),
      .cos_i (cos_v),
      .sin_i (sin_v),
      .re_i  ($signed(smp_chain[N][3*SB-1:2*SB])),
      .im_i  ($signed(smp_chain[N][4*SB-1:3*SB])),
      .re_o  (v_re),
      .im_o  (v_im)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else if (en) begin
         prod_vld_ff <= ctl_chain[N].valid;
         rsp_vld_ff  <= prod_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_last_ff <= ctl_chain[N].last;
         rsp_last_ff  <= prod_last_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = DATA_W'({v_im, v_re, h_im, h_re});

`ifndef NO_ASSERTIONS
   a_accept_enters_chain: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> ctl_chain[0].valid)
      else $error("accepted sample did not enter the phase stage");

   a_stall_holds_chain: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(prod_vld_ff) && $stable(ctl_chain[N])))
      else $error("pipeline advanced while output stalled");

   a_out_from_prod: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(prod_vld_ff))
      else $error("result appeared without a product stage entry");

   a_cordic_cos_range: assert property (@(posedge clock) disable iff (reset)
      ctl_chain[N].valid |-> (x_chain[N] > 32'sd700000000 && x_chain[N] < 32'sd1100000000))
      else $error("CORDIC cosine out of the folded range");
`endif

endmodule
`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench of the Doppler phase rotator: directed rows, then random records.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import dpr_pkg::*;

   localparam int STAGES = 16;
   localparam int LATENCY = STAGES + 3;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_PAIRS = 1750;
   localparam int DIRECTED_ROWS = 23;
   localparam longint CORDIC_SCALE = 64'sd652032874;
   // atan(2^-i) in 2^-32 turn, truncated
   localparam longint ARC_STEP [0:STAGES-1] = '{
      536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335086, 667544, 333772,
      166886, 83443, 41721, 20860
   };

   typedef struct packed {
      logic signed [15:0] h_re;
      logic signed [15:0] h_im;
      logic signed [15:0] v_re;
      logic signed [15:0] v_im;
      logic               last;
   } pair_type;

   typedef struct packed {
      bit        is_cfg;
      bit [31:0] step;
      bit        typed;
      pair_type  stim;
      pair_type  want;
   } row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [63:0]           req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [63:0]           rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wr_en = 1'b0;
   logic [ANGLE_BITS-1:0] csr_wr_data = '0;

   bit [31:0] step_reg = 32'h8000_0000;
   bit [31:0] phase_acc = '0;
   pair_type  rotated_q [$];
   int        errors = 0;
   int        idle_cycles = 0;
   bit        tx_calm = 1'b0;
   bit        rx_calm = 1'b0;
   row_type   dir_rows [DIRECTED_ROWS];

   always #10 clock = ~clock;

   doppler_phase_rotator uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   function automatic logic signed [15:0] round_sat(longint p);
      longint v;
      v = (p + (64'sd1 <<< 29)) >>> 30;
      if (v > 32767) begin
         v = 32767;
      end else if (v < -32768) begin
         v = -32768;
      end
      return 16'(v);
   endfunction

   // advance the NCO by one sample and rotate both channels
   function automatic pair_type rotate_pair(pair_type s);
      bit [31:0]    fold;
      dpr_quad_type quad;
      longint       x, y, z, dx, dy, c, sn;
      pair_type     r;
      phase_acc = phase_acc + step_reg;
      fold = phase_acc + 32'h2000_0000;
      quad = dpr_quad_type'(fold[31:30]);
      z = longint'($signed(phase_acc - {quad, 30'd0}));
      x = CORDIC_SCALE;
      y = 0;
      for (int i = 0; i < STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ARC_STEP[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ARC_STEP[i];
         end
      end
      case (quad)
         QUAD_0: begin
            c = x;
            sn = y;
         end
         QUAD_90: begin
            c = -y;
            sn = x;
         end
         QUAD_180: begin
            c = -x;
            sn = -y;
         end
         default: begin
            c = y;
            sn = -x;
         end
      endcase
      r.h_re = round_sat(s.h_re * c - s.h_im * sn);
      r.h_im = round_sat(s.h_re * sn + s.h_im * c);
      r.v_re = round_sat(s.v_re * c - s.v_im * sn);
      r.v_im = round_sat(s.v_re * sn + s.v_im * c);
      r.last = s.last;
      // restart the record
      if (s.last) begin
         phase_acc = '0;
      end
      return r;
   endfunction

   function automatic int draw_gap(bit calm);
      if (calm || $urandom_range(0, 2) == 0) begin
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   function automatic logic signed [15:0] draw_sample();
      case ($urandom_range(0, 9))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'sd0;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic row_type pair_row(int hr, int hi, int vr, int vi, bit last);
      row_type r;
      r = '0;
      r.stim.h_re = 16'(hr);
      r.stim.h_im = 16'(hi);
      r.stim.v_re = 16'(vr);
      r.stim.v_im = 16'(vi);
      r.stim.last = last;
      return r;
   endfunction

   // all-zero samples rotate to zero at any phase
   function automatic row_type zero_row(bit last);
      row_type r;
      r = '0;
      r.stim.last = last;
      r.typed = 1'b1;
      r.want.last = last;
      return r;
   endfunction

   function automatic row_type cfg_row(bit [31:0] v);
      row_type r;
      r = '0;
      r.is_cfg = 1'b1;
      r.step = v;
      return r;
   endfunction

   task automatic send_pair(pair_type p, bit typed, pair_type want);
      int       gap;
      pair_type predicted;
      gap = draw_gap(tx_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {p.v_im, p.v_re, p.h_im, p.h_re};
      req_tlast <= p.last;
      do @(posedge clock); while (!req_tready);
      predicted = rotate_pair(p);
      rotated_q.push_back(typed ? want : predicted);
   endtask

   // write only with the pipeline drained
   task automatic load_phase_step(bit [31:0] v);
      req_tvalid <= 1'b0;
      while (rotated_q.size() != 0) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      step_reg = v;
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // result side
   initial begin
      int       stall;
      pair_type got;
      pair_type want;
      @(negedge reset);
      forever begin
         stall = draw_gap(rx_calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.h_re = rsp_tdata[15:0];
         got.h_im = rsp_tdata[31:16];
         got.v_re = rsp_tdata[47:32];
         got.v_im = rsp_tdata[63:48];
         got.last = rsp_tlast;
         if (rotated_q.size() == 0) begin
            errors++;
            $display("%0t: transfer with nothing expected, got %h last %b", $time,
                     rsp_tdata, rsp_tlast);
         end else begin
            want = rotated_q.pop_front();
            check_field("h_real_out", want.h_re, got.h_re);
            check_field("h_imag_out", want.h_im, got.h_im);
            check_field("v_real_out", want.v_re, got.v_re);
            check_field("v_imag_out", want.v_im, got.v_im);
            check_field("last_out", want.last, got.last);
         end
         if ($urandom_range(0, 99) == 0) begin
            rx_calm = !rx_calm;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   initial begin
      int        pairs_sent;
      int        run_len;
      int        phase_len;
      bit [31:0] new_step;
      pair_type  p;
      dir_rows = '{
         // reset step is a half turn
         zero_row(1'b0),
         pair_row(32767, 32767, 32767, 32767, 1'b0),
         pair_row(-32768, -32768, -32768, -32768, 1'b0),
         pair_row(32767, -32768, -32768, 32767, 1'b1),
         pair_row(-32768, 32767, 1, -1, 1'b1),
         // eighth turn: quadrant boundary and saturating diagonals
         cfg_row(32'h2000_0000),
         pair_row(32767, 32767, -32768, -32768, 1'b0),
         pair_row(32767, -32768, -32768, 32767, 1'b0),
         pair_row(-32768, -32768, 32767, 32767, 1'b0),
         pair_row(-32768, 32767, 32767, -32768, 1'b0),
         pair_row(12345, -23456, -1, 0, 1'b1),
         cfg_row(32'h0000_0000),
         zero_row(1'b0),
         pair_row(32767, -32768, 32767, -32768, 1'b0),
         pair_row(-32768, -32768, -32768, -32768, 1'b1),
         cfg_row(32'hFFFF_FFFF),
         pair_row(32767, 0, 0, 32767, 0),
         pair_row(-1, -1, 1, 1, 1'b0),
         // step change inside a record keeps the accumulated phase
         cfg_row(32'h4000_0000),
         pair_row(32767, -32768, -32768, 32767, 1'b0),
         pair_row(-32768, 32767, 32767, -32768, 1'b0),
         pair_row(21845, -21846, -32768, 32767, 1'b0),
         zero_row(1'b1)
      };
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) begin
            load_phase_step(dir_rows[i].step);
         end else begin
            send_pair(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
         end
      end

      pairs_sent = 0;
      while (pairs_sent < RANDOM_PAIRS) begin
         case ($urandom_range(0, 5))
            0: new_step = 32'h0000_0000;
            1: new_step = 32'hFFFF_FFFF;
            2: new_step = 32'h8000_0000;
            3: new_step = $urandom_range(0, 65536);
            default: new_step = $urandom;
         endcase
         load_phase_step(new_step);
         tx_calm = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(100, 300);
         if (phase_len > RANDOM_PAIRS - pairs_sent) begin
            phase_len = RANDOM_PAIRS - pairs_sent;
         end
         run_len = 0;
         // a phase may end inside a record
         repeat (phase_len) begin
            if (run_len == 0) begin
               run_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
            end
            p.h_re = draw_sample();
            p.h_im = draw_sample();
            p.v_re = draw_sample();
            p.v_im = draw_sample();
            run_len--;
            p.last = (run_len == 0);
            send_pair(p, 1'b0, '0);
            pairs_sent++;
         end
      end

      req_tvalid <= 1'b0;
      while (rotated_q.size() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      if (errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
